FILE: design/spm_pkg.sv
// ----------------------------------------------------------------------------
// Stuck pedal monitor package
// Shared beat layouts, register indexes, phase encoding and helper functions.
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int unsigned DATA_W      = 16;
    localparam int unsigned LATCH_W     = 11;
    localparam int unsigned NUM_REGS    = 8;
    localparam int unsigned REG_IDX_W   = 3;
    localparam int unsigned SPEED_SHIFT = 7;   // raw speed times 128
    localparam int unsigned SPEED_RAW_W = 8;
    localparam logic [LATCH_W-1:0] PEDAL_CAP = LATCH_W'(1024);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PEDAL_MIN     = 3'd0,
        REG_SPEED_MIN     = 3'd1,
        REG_RPM_MIN       = 3'd2,
        REG_STEADY_DELTA  = 3'd3,
        REG_PEDAL_HYST    = 3'd4,
        REG_SPEED_HYST    = 3'd5,
        REG_RPM_HYST      = 3'd6,
        REG_RELEASE_DELTA = 3'd7
    } reg_idx_t;

    // Phase codes as reported on diag_phase
    localparam logic [2:0] PH_CODE_INIT      = 3'd0;
    localparam logic [2:0] PH_CODE_INACTIVE  = 3'd1;
    localparam logic [2:0] PH_CODE_SUSPECTED = 3'd2;
    localparam logic [2:0] PH_CODE_CONFIRMED = 3'd3;
    localparam logic [2:0] PH_CODE_DEVALID   = 3'd4;

    typedef enum logic [4:0] {
        PH_INIT      = 5'b00001,
        PH_INACTIVE  = 5'b00010,
        PH_SUSPECTED = 5'b00100,
        PH_CONFIRMED = 5'b01000,
        PH_DEVALID   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [DATA_W-1:0]      pedal_position;
        logic [SPEED_RAW_W-1:0] vehicle_speed;
        logic [DATA_W-1:0]      engine_speed;
        logic                   brake_switch;
        logic                   brake_pressure_switch;
        logic                   brake_signal_invalid;
        logic                   monitor_inhibit;
        logic                   fault_confirmed;
    } sample_t;

    typedef struct packed {
        logic               monitor_running;
        logic               fault_seen;
        logic [2:0]         diag_phase;
        logic [LATCH_W-1:0] latched_pedal;
        logic               brake_pressed;
    } result_t;

    typedef struct packed {
        reg_idx_t          index;
        logic [DATA_W-1:0] data;
    } cfg_write_t;

    // Classified tick handed from the front end to the state machine
    typedef struct packed {
        logic [DATA_W-1:0] pedal;
        logic              brake_q;
        logic              confirmed;
        logic              arm_ok;     // static arming terms, incl. not inhibited
        logic              exit_hit;   // static exit terms, incl. inhibited
    } class_t;

    typedef struct packed {
        logic [DATA_W-1:0] steady_delta;
        logic [DATA_W-1:0] release_delta;
    } back_cfg_t;

    function automatic logic [DATA_W-1:0] abs_diff(input logic [DATA_W-1:0] a,
                                                   input logic [DATA_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [LATCH_W-1:0] cap_pedal(input logic [DATA_W-1:0] v);
        return (v > DATA_W'(PEDAL_CAP)) ? PEDAL_CAP : v[LATCH_W-1:0];
    endfunction

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        case (ph)
            PH_INIT:      code = PH_CODE_INIT;
            PH_INACTIVE:  code = PH_CODE_INACTIVE;
            PH_SUSPECTED: code = PH_CODE_SUSPECTED;
            PH_CONFIRMED: code = PH_CODE_CONFIRMED;
            PH_DEVALID:   code = PH_CODE_DEVALID;
            default:      code = PH_CODE_INIT;
        endcase
        return code;
    endfunction

endpackage

FILE: design/spm_stream_if.sv
// ----------------------------------------------------------------------------
// Stuck pedal monitor stream channel
// Valid/ready channel carrying one payload beat; a beat moves when both are high.
// ----------------------------------------------------------------------------
interface spm_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/spm_front.sv
// ----------------------------------------------------------------------------
// Stuck pedal monitor front end
// Holds the configuration registers and classifies each sample beat against
// the arming and hysteresis thresholds before it enters the queue.
// ----------------------------------------------------------------------------
module spm_front (
    input  logic               clk,
    input  logic               rst_n,
    spm_stream_if.sink         sample,
    spm_stream_if.sink         cfg,
    output logic               push_valid,
    output spm_pkg::class_t    push_data,
    input  logic               push_ready,
    output spm_pkg::back_cfg_t back_cfg
);
    import spm_pkg::*;

    logic [DATA_W-1:0] cfg_reg [NUM_REGS];
    logic [DATA_W-1:0] speed_scaled;
    logic signed [DATA_W:0] pedal_thr;
    logic signed [DATA_W:0] speed_thr;
    logic signed [DATA_W:0] rpm_thr;
    logic arm_static;
    logic exit_static;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{default: '0};
        end
        else if (cfg.valid)
        begin
            cfg_reg[cfg.payload.index] <= cfg.payload.data;
        end
    end

    always_comb
    begin
        speed_scaled = DATA_W'({sample.payload.vehicle_speed, SPEED_SHIFT'(0)});

        // exit thresholds are signed: a negative one never fires
        pedal_thr = $signed({1'b0, cfg_reg[REG_PEDAL_MIN]})
                  - $signed({1'b0, cfg_reg[REG_PEDAL_HYST]});
        speed_thr = $signed({1'b0, cfg_reg[REG_SPEED_MIN]})
                  - $signed({1'b0, cfg_reg[REG_SPEED_HYST]});
        rpm_thr   = $signed({1'b0, cfg_reg[REG_RPM_MIN]})
                  - $signed({1'b0, cfg_reg[REG_RPM_HYST]});

        arm_static = (sample.payload.pedal_position > cfg_reg[REG_PEDAL_MIN])
                  && (speed_scaled > cfg_reg[REG_SPEED_MIN])
                  && (sample.payload.engine_speed > cfg_reg[REG_RPM_MIN])
                  && !sample.payload.monitor_inhibit;

        exit_static = ($signed({1'b0, sample.payload.pedal_position}) <= pedal_thr)
                   || ($signed({1'b0, speed_scaled}) <= speed_thr)
                   || ($signed({1'b0, sample.payload.engine_speed}) <= rpm_thr)
                   || sample.payload.monitor_inhibit;

        push_data.pedal     = sample.payload.pedal_position;
        push_data.brake_q   = sample.payload.brake_switch
                           && sample.payload.brake_pressure_switch
                           && !sample.payload.brake_signal_invalid;
        push_data.confirmed = sample.payload.fault_confirmed;
        push_data.arm_ok    = arm_static;
        push_data.exit_hit  = exit_static;
    end

    assign push_valid   = sample.valid;
    assign sample.ready = push_ready;

    assign back_cfg.steady_delta  = cfg_reg[REG_STEADY_DELTA];
    assign back_cfg.release_delta = cfg_reg[REG_RELEASE_DELTA];

endmodule

FILE: design/spm_queue.sv
// ----------------------------------------------------------------------------
// Stuck pedal monitor queue
// Short FIFO of classified beats between the front end and the state machine.
// ----------------------------------------------------------------------------
module spm_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  spm_pkg::class_t push_data,
    output logic            push_ready,
    output logic            pop_valid,
    output spm_pkg::class_t pop_data,
    input  logic            pop_ready
);
    import spm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    class_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count missed a push");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue empty with pointers apart");

endmodule

FILE: design/spm_back.sv
// ----------------------------------------------------------------------------
// Stuck pedal monitor state machine
// Runs the diagnostic phases on each classified beat and registers the result.
// ----------------------------------------------------------------------------
module spm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    input  spm_pkg::class_t    pop_data,
    output logic               pop_ready,
    input  spm_pkg::back_cfg_t back_cfg,
    spm_stream_if.source       result
);
    import spm_pkg::*;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [LATCH_W-1:0] latch_reg;
    logic [LATCH_W-1:0] latch_next;
    logic [LATCH_W-1:0] last_reg;
    logic               brake_reg;
    logic               running_reg;
    logic               running_next;
    logic               detected_reg;
    logic               detected_next;
    logic               out_valid_reg;
    result_t            out_data_reg;
    result_t            out_data_next;

    logic [DATA_W-1:0]  latch_src;
    logic [LATCH_W-1:0] step;
    logic               steady;
    logic               moved_far;
    logic               brake_rise;
    logic               take;

    assign pop_ready = !out_valid_reg || result.ready;
    assign take      = pop_valid && pop_ready;

    always_comb
    begin
        step       = cap_pedal(abs_diff(pop_data.pedal, DATA_W'(last_reg)));
        steady     = DATA_W'(step) < back_cfg.steady_delta;
        moved_far  = abs_diff(pop_data.pedal, DATA_W'(latch_reg)) >= back_cfg.release_delta;
        brake_rise = pop_data.brake_q && !brake_reg;

        phase_next    = phase_reg;
        running_next  = running_reg;
        detected_next = detected_reg;
        latch_src     = DATA_W'(latch_reg);

        case (phase_reg)
            PH_INIT:
            begin
                phase_next    = PH_INACTIVE;
                running_next  = 1'b0;
                detected_next = 1'b0;
                latch_src     = pop_data.pedal;
            end
            PH_INACTIVE:
            begin
                if (pop_data.confirmed)
                begin
                    phase_next    = PH_CONFIRMED;
                    running_next  = 1'b1;
                    detected_next = 1'b1;
                end
                else if (pop_data.arm_ok && steady && brake_rise)
                begin
                    phase_next    = PH_SUSPECTED;
                    running_next  = 1'b1;
                    detected_next = 1'b1;
                    latch_src     = pop_data.pedal;
                end
            end
            PH_SUSPECTED:
            begin
                if (pop_data.confirmed)
                begin
                    phase_next    = PH_CONFIRMED;
                    running_next  = 1'b1;
                    detected_next = 1'b1;
                end
                else if (pop_data.exit_hit || moved_far || !pop_data.brake_q)
                begin
                    phase_next    = PH_INACTIVE;
                    running_next  = 1'b0;
                    detected_next = 1'b0;
                    latch_src     = pop_data.pedal;
                end
            end
            PH_CONFIRMED:
            begin
                if (moved_far && !pop_data.brake_q)
                begin
                    phase_next    = PH_DEVALID;
                    detected_next = 1'b0;
                end
            end
            PH_DEVALID:
            begin
                if (!pop_data.confirmed)
                begin
                    phase_next    = PH_INACTIVE;
                    running_next  = 1'b0;
                    detected_next = 1'b0;
                    latch_src     = pop_data.pedal;
                end
                else if (!moved_far || pop_data.brake_q)
                begin
                    phase_next    = PH_CONFIRMED;
                    running_next  = 1'b1;
                    detected_next = 1'b1;
                end
            end
            default:
            begin
                // corrupted phase: restart, keep the flags
                phase_next = PH_INIT;
                latch_src  = pop_data.pedal;
            end
        endcase

        latch_next = cap_pedal(latch_src);

        out_data_next.monitor_running = running_next;
        out_data_next.fault_seen      = detected_next;
        out_data_next.diag_phase      = phase_code(phase_next);
        out_data_next.latched_pedal   = latch_next;
        out_data_next.brake_pressed   = pop_data.brake_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_INIT;
            latch_reg     <= '0;
            last_reg      <= '0;
            brake_reg     <= 1'b0;
            running_reg   <= 1'b0;
            detected_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg    <= phase_next;
                latch_reg    <= latch_next;
                last_reg     <= cap_pedal(pop_data.pedal);
                brake_reg    <= pop_data.brake_q;
                running_reg  <= running_next;
                detected_reg <= detected_next;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("phase register lost its one-hot code");

    a_detect_running: assert property (@(posedge clk) disable iff (!rst_n)
        detected_reg |-> running_reg)
        else $error("fault seen while monitor not running");

    a_latch_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (latch_reg <= PEDAL_CAP) && (last_reg <= PEDAL_CAP))
        else $error("pedal latch above saturation");

    a_confirmed_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CONFIRMED) |-> (running_reg && detected_reg))
        else $error("confirmed phase without both flags");

endmodule

FILE: design/stuck_pedal_monitor.sv
// ----------------------------------------------------------------------------
// Stuck pedal monitor
// Watches for an accelerator pedal held while the driver brakes.
// ----------------------------------------------------------------------------
// One sample beat yields one result beat. The block takes a sample in every
// cycle while the result side is not stalled and delivers results in order
// through a queue slot and the output register. The front end compares the
// sample against the thresholds, a queue of QUEUE_DEPTH beats decouples it
// from the phase machine, and the machine, updating its state on each beat
// it takes, sets the sustained rate of one item per cycle. The result sits in
// an output register, so a stalled result side holds it while up to
// QUEUE_DEPTH more samples are taken. Configuration writes are always
// accepted and are to be issued only while no sample is in flight.
module stuck_pedal_monitor #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    spm_stream_if.sink   sample,
    spm_stream_if.source result,
    spm_stream_if.sink   cfg
);
    import spm_pkg::*;

    logic      push_valid;
    class_t    push_data;
    logic      push_ready;
    logic      pop_valid;
    class_t    pop_data;
    logic      pop_ready;
    back_cfg_t back_cfg;

    spm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .back_cfg   (back_cfg)
    );

    spm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    spm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .back_cfg  (back_cfg),
        .result    (result)
    );

endmodule

FILE: test/tb_stuck_pedal_monitor.sv
// ----------------------------------------------------------------------------
// Stuck pedal monitor testbench
// Feeds pedal, speed, rpm and brake samples under several threshold settings.
// An in-bench copy of the diagnostic phase machine predicts every result beat,
// and each beat is compared field by field. A short table of directed ticks
// walks arming, the inhibit, speed, rpm and pedal exits, confirmation and
// devalidation. Random sequences follow, most of them plausible pedal and brake traces.
// ----------------------------------------------------------------------------
module tb_stuck_pedal_monitor;

    import spm_pkg::*;

    typedef struct {
        sample_t s;
        bit      known;
        result_t r;
    } dir_row_t;

    logic clk;
    logic rst_n;

    spm_stream_if #(.payload_t(sample_t))    sample_if ();
    spm_stream_if #(.payload_t(result_t))    result_if ();
    spm_stream_if #(.payload_t(cfg_write_t)) cfg_if ();

    stuck_pedal_monitor u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    // Threshold copy and phase machine state of the predictor
    logic [DATA_W-1:0]  cfg_regs [NUM_REGS] = '{default: '0};
    logic [2:0]         ph_q     = PH_CODE_INIT;
    logic [LATCH_W-1:0] latch_q  = '0;
    logic [LATCH_W-1:0] last_q   = '0;
    logic               brk_now  = 1'b0;
    logic               brk_prev = 1'b0;
    logic               run_q    = 1'b0;
    logic               seen_q   = 1'b0;

    result_t pending_results [$];

    // Random trace state
    int unsigned pedal_walk = 0;
    bit          brake_held = 1'b0;
    bit          fault_held = 1'b0;
    bit          idle_on    = 1'b1;

    int n_items    = 0;
    int n_checked  = 0;
    int n_bad      = 0;
    int n_settings = 0;
    int n_arm      = 0;
    int n_conf     = 0;
    int n_deval    = 0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #4_000_000;
        $display("FAIL stuck_pedal_monitor");
        $finish;
    end

    function automatic int unsigned pedal_dist(input int unsigned a, input int unsigned b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [LATCH_W-1:0] clamp_pedal(input int unsigned v);
        return (v > PEDAL_CAP) ? PEDAL_CAP : LATCH_W'(v);
    endfunction

    function automatic int clamp_int(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic sample_t tick_in(input int p, input int v, input int r, input bit bs,
                                        input bit bp, input bit bi, input bit inh,
                                        input bit cf);
        sample_t s;
        s.pedal_position        = DATA_W'(p);
        s.vehicle_speed         = SPEED_RAW_W'(v);
        s.engine_speed          = DATA_W'(r);
        s.brake_switch          = bs;
        s.brake_pressure_switch = bp;
        s.brake_signal_invalid  = bi;
        s.monitor_inhibit       = inh;
        s.fault_confirmed       = cf;
        return s;
    endfunction

    function automatic result_t tick_out(input bit run, input bit seen, input logic [2:0] ph,
                                         input int lat, input bit brk);
        result_t r;
        r.monitor_running = run;
        r.fault_seen      = seen;
        r.diag_phase      = ph;
        r.latched_pedal   = LATCH_W'(lat);
        r.brake_pressed   = brk;
        return r;
    endfunction

    function automatic dir_row_t calc_row(input sample_t s);
        dir_row_t row;
        row.s     = s;
        row.known = 1'b0;
        row.r     = '0;
        return row;
    endfunction

    function automatic dir_row_t known_row(input sample_t s, input result_t r);
        dir_row_t row;
        row.s     = s;
        row.known = 1'b1;
        row.r     = r;
        return row;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int unsigned roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Advance the phase machine by one tick and produce its result beat
    task automatic predict_tick(input sample_t s, output result_t r);
        int unsigned pedal, speed, rpm, moved, step, lat;
        int pth, sth, rth;
        pedal = s.pedal_position;
        speed = 32'(s.vehicle_speed) * 128;
        rpm   = s.engine_speed;
        moved = pedal_dist(pedal, latch_q);
        lat   = latch_q;
        brk_prev = brk_now;
        brk_now  = s.brake_switch & s.brake_pressure_switch & ~s.brake_signal_invalid;
        // exit thresholds may go negative and then never trigger
        pth = int'(cfg_regs[REG_PEDAL_MIN]) - int'(cfg_regs[REG_PEDAL_HYST]);
        sth = int'(cfg_regs[REG_SPEED_MIN]) - int'(cfg_regs[REG_SPEED_HYST]);
        rth = int'(cfg_regs[REG_RPM_MIN]) - int'(cfg_regs[REG_RPM_HYST]);
        case (ph_q)
            PH_CODE_INIT:
            begin
                ph_q   = PH_CODE_INACTIVE;
                run_q  = 1'b0;
                seen_q = 1'b0;
                lat    = pedal;
            end
            PH_CODE_INACTIVE:
            begin
                step = clamp_pedal(pedal_dist(pedal, last_q));
                if (s.fault_confirmed)
                begin
                    run_q  = 1'b1;
                    seen_q = 1'b1;
                    ph_q   = PH_CODE_CONFIRMED;
                    n_conf++;
                end
                else if (pedal > cfg_regs[REG_PEDAL_MIN] && speed > cfg_regs[REG_SPEED_MIN] &&
                         rpm > cfg_regs[REG_RPM_MIN] && step < cfg_regs[REG_STEADY_DELTA] &&
                         brk_now && !brk_prev && !s.monitor_inhibit)
                begin
                    run_q  = 1'b1;
                    seen_q = 1'b1;
                    ph_q   = PH_CODE_SUSPECTED;
                    lat    = pedal;
                    n_arm++;
                end
            end
            PH_CODE_SUSPECTED:
            begin
                if (s.fault_confirmed)
                begin
                    run_q  = 1'b1;
                    seen_q = 1'b1;
                    ph_q   = PH_CODE_CONFIRMED;
                    n_conf++;
                end
                else if (int'(pedal) <= pth || int'(speed) <= sth || int'(rpm) <= rth ||
                         moved >= cfg_regs[REG_RELEASE_DELTA] || !brk_now ||
                         s.monitor_inhibit)
                begin
                    ph_q   = PH_CODE_INACTIVE;
                    run_q  = 1'b0;
                    seen_q = 1'b0;
                    lat    = pedal;
                end
            end
            PH_CODE_CONFIRMED:
            begin
                if (moved >= cfg_regs[REG_RELEASE_DELTA] && !brk_now)
                begin
                    ph_q   = PH_CODE_DEVALID;
                    seen_q = 1'b0;
                    n_deval++;
                end
            end
            PH_CODE_DEVALID:
            begin
                if (!s.fault_confirmed)
                begin
                    ph_q   = PH_CODE_INACTIVE;
                    run_q  = 1'b0;
                    seen_q = 1'b0;
                    lat    = pedal;
                end
                else if (moved < cfg_regs[REG_RELEASE_DELTA] || brk_now)
                begin
                    run_q  = 1'b1;
                    seen_q = 1'b1;
                    ph_q   = PH_CODE_CONFIRMED;
                end
            end
            default:
            begin
                ph_q = PH_CODE_INIT;
                lat  = pedal;
            end
        endcase
        latch_q = clamp_pedal(lat);
        last_q  = clamp_pedal(pedal);
        r = tick_out(run_q, seen_q, ph_q, latch_q, brk_now);
    endtask

    // Plausible pedal and brake trace near the current thresholds, with some noise
    task automatic make_sample(output sample_t s);
        logic [63:0] raw;
        int unsigned roll;
        int          v, r;
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            raw = {$urandom, $urandom};
            s   = raw[$bits(sample_t)-1:0];
            return;
        end
        if (roll < 20)
            pedal_walk = clamp_int(int'(cfg_regs[REG_PEDAL_MIN]) +
                                   int'($urandom_range(40)) - 20, 0, 65535);
        else if ($urandom_range(7) == 0)
            pedal_walk = $urandom_range(1100);
        else
            pedal_walk = clamp_int(int'(pedal_walk) + int'($urandom_range(60)) - 30, 0, 65535);
        v = clamp_int(int'(cfg_regs[REG_SPEED_MIN] >> SPEED_SHIFT) +
                      int'($urandom_range(6)) - 2, 0, 255);
        if (roll < 15)
            v = $urandom_range(255);
        r = clamp_int(int'(cfg_regs[REG_RPM_MIN]) + int'($urandom_range(400)) - 150, 0, 65535);
        if ($urandom_range(3) == 0)
            brake_held = ~brake_held;
        if ($urandom_range(24) == 0)
            fault_held = ~fault_held;
        s = tick_in(pedal_walk, v, r, brake_held, brake_held, $urandom_range(29) == 0,
                    $urandom_range(19) == 0, fault_held);
        if ($urandom_range(19) == 0)
            s.brake_pressure_switch = ~s.brake_pressure_switch;
        if ($urandom_range(19) == 0)
            s.brake_switch = ~s.brake_switch;
    endtask

    // Send one sample beat; take the typed result where given, else the prediction
    task automatic issue(input sample_t s, input bit known, input result_t fixed);
        int      gap;
        result_t calc;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_if.valid   <= 1'b1;
        sample_if.payload <= s;
        do @(posedge clk); while (!sample_if.ready);
        predict_tick(s, calc);
        pending_results.push_back(known ? fixed : calc);
        n_items++;
    endtask

    // Drop valid and wait until every expected beat is back
    task automatic drain_results(input int extra);
        @(negedge clk);
        sample_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
        cfg_write_t w;
        w.index = idx;
        w.data  = val;
        @(negedge clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= w;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_regs[idx] = val;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_config(input int pm, input int sm, input int rm, input int sd,
                              input int ph, input int sh, input int rh, input int rd);
        write_reg(REG_PEDAL_MIN, DATA_W'(pm));
        write_reg(REG_SPEED_MIN, DATA_W'(sm));
        write_reg(REG_RPM_MIN, DATA_W'(rm));
        write_reg(REG_STEADY_DELTA, DATA_W'(sd));
        write_reg(REG_PEDAL_HYST, DATA_W'(ph));
        write_reg(REG_SPEED_HYST, DATA_W'(sh));
        write_reg(REG_RPM_HYST, DATA_W'(rh));
        write_reg(REG_RELEASE_DELTA, DATA_W'(rd));
        n_settings++;
    endtask

    // Random result side stalls
    initial
    begin
        int stall;
        stall = 0;
        result_if.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                stall--;
            end
            else
            begin
                result_if.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got = result_if.payload;
            if (pending_results.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("result beat with nothing expected: run=%0b seen=%0b phase=%0d latch=%0d brake=%0b",
                             got.monitor_running, got.fault_seen, got.diag_phase,
                             got.latched_pedal, got.brake_pressed);
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.monitor_running !== want.monitor_running ||
                    got.fault_seen !== want.fault_seen ||
                    got.diag_phase !== want.diag_phase ||
                    got.latched_pedal !== want.latched_pedal ||
                    got.brake_pressed !== want.brake_pressed)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("beat %0d mismatch: expected run=%0b seen=%0b phase=%0d latch=%0d brake=%0b, got run=%0b seen=%0b phase=%0d latch=%0d brake=%0b",
                                 n_checked, want.monitor_running, want.fault_seen,
                                 want.diag_phase, want.latched_pedal, want.brake_pressed,
                                 got.monitor_running, got.fault_seen, got.diag_phase,
                                 got.latched_pedal, got.brake_pressed);
                end
            end
        end
    end

    initial
    begin
        dir_row_t dir_rows [$];
        sample_t  s;
        int       drain_at;
        sample_if.valid   = 1'b0;
        sample_if.payload = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.payload    = '0;
        rst_n             = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_config(100, 1000, 800, 50, 20, 200, 100, 30);

        // Arm needs pedal > 100, speed raw >= 8, rpm > 800, step < 50.
        // Exit at pedal <= 80, speed raw <= 6, rpm <= 700, move >= 30.
        dir_rows = '{
            // first tick leaves init and latches the saturated pedal
            known_row(tick_in(65535, 255, 65535, 1, 1, 0, 0, 0),
                      tick_out(0, 0, PH_CODE_INACTIVE, 1024, 1)),
            // invalid bus signal masks the brake
            known_row(tick_in(65535, 255, 65535, 1, 1, 1, 0, 0),
                      tick_out(0, 0, PH_CODE_INACTIVE, 1024, 0)),
            calc_row(tick_in(65535, 255, 65535, 1, 1, 0, 1, 0)),
            calc_row(tick_in(500, 0, 0, 0, 1, 0, 0, 0)),
            known_row(tick_in(510, 8, 900, 1, 1, 0, 0, 0),
                      tick_out(1, 1, PH_CODE_SUSPECTED, 510, 1)),
            calc_row(tick_in(515, 8, 900, 1, 1, 0, 0, 0)),
            // inhibit drops the suspicion
            known_row(tick_in(515, 8, 900, 1, 1, 0, 1, 0),
                      tick_out(0, 0, PH_CODE_INACTIVE, 515, 1)),
            calc_row(tick_in(515, 8, 900, 1, 0, 0, 0, 0)),
            calc_row(tick_in(515, 8, 900, 1, 1, 0, 0, 0)),
            calc_row(tick_in(515, 6, 900, 1, 1, 0, 0, 0)),
            calc_row(tick_in(515, 8, 900, 0, 1, 0, 0, 0)),
            calc_row(tick_in(515, 8, 900, 1, 1, 0, 0, 0)),
            calc_row(tick_in(515, 8, 700, 1, 1, 0, 0, 0)),
            calc_row(tick_in(101, 8, 900, 0, 0, 0, 0, 0)),
            calc_row(tick_in(101, 8, 900, 1, 1, 0, 0, 0)),
            calc_row(tick_in(80, 8, 900, 1, 1, 0, 0, 0)),
            known_row(tick_in(80, 8, 900, 1, 1, 0, 0, 1),
                      tick_out(1, 1, PH_CODE_CONFIRMED, 80, 1)),
            calc_row(tick_in(85, 0, 0, 0, 0, 0, 0, 1)),
            calc_row(tick_in(200, 0, 0, 1, 1, 0, 0, 1)),
            // pedal moved away with brake released
            known_row(tick_in(200, 0, 0, 0, 0, 0, 0, 1),
                      tick_out(1, 0, PH_CODE_DEVALID, 80, 0)),
            calc_row(tick_in(90, 0, 0, 0, 0, 0, 0, 1)),
            calc_row(tick_in(200, 0, 0, 0, 0, 0, 0, 1)),
            known_row(tick_in(300, 0, 0, 0, 0, 0, 0, 0),
                      tick_out(0, 0, PH_CODE_INACTIVE, 300, 0)),
            calc_row(tick_in(120, 8, 900, 0, 0, 0, 0, 0)),
            calc_row(tick_in(130, 8, 900, 1, 1, 0, 0, 0)),
            known_row(tick_in(130, 8, 900, 1, 1, 0, 0, 1),
                      tick_out(1, 1, PH_CODE_CONFIRMED, 130, 1))
        };
        foreach (dir_rows[i])
            issue(dir_rows[i].s, dir_rows[i].known, dir_rows[i].r);

        for (int k = 0; k < 6; k++)
        begin
            drain_results(4);
            case (k)
                1: set_config(0, 0, 0, 0, 0, 0, 0, 0);
                3: set_config(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535);
                // arms freely; hysteresis never exits, only brake or inhibit
                4: set_config(0, 0, 0, 65535, 65535, 65535, 65535, 65535);
                default: set_config($urandom_range(900), $urandom_range(30000),
                                    $urandom_range(5000), $urandom_range(1, 200),
                                    $urandom_range(300), $urandom_range(3000),
                                    $urandom_range(600), $urandom_range(1, 300));
            endcase
            drain_at = $urandom_range(40, 140);
            for (int i = 0; i < 155; i++)
            begin
                // back-to-back beats on both sides for the opening stretch
                idle_on = (i >= 30);
                if (i == drain_at)
                    drain_results(0);
                make_sample(s);
                issue(s, 1'b0, '0);
            end
        end

        drain_results(8);
        $display("covered %0d samples over %0d threshold settings, %0d result beats checked",
                 n_items, n_settings, n_checked);
        $display("predicted %0d arms, %0d confirmations, %0d devalidations; %0d mismatches",
                 n_arm, n_conf, n_deval, n_bad);
        if (n_bad == 0)
            $display("PASS stuck_pedal_monitor");
        else
            $display("FAIL stuck_pedal_monitor");
        $finish;
    end

endmodule
